>>> hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define AFN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked assertion that also holds during reset
`define AFN_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed during reset");

`endif

>>> hdl/afn_pkg.sv
// shared types, constants and helpers for the fade / normalize block
// no dependencies
package afn_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;
  // operand width of the scaler: holds a length or a peak value
  localparam int OP_W        = (LENGTH_BITS > SAMPLE_W) ? LENGTH_BITS : SAMPLE_W;
  // quotient bits kept; anything larger clamps
  localparam int Q_W         = SAMPLE_W + 1;
  localparam int PROD_W      = OP_W + Q_W;
  localparam int STEP_W      = $clog2(Q_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [Q_W-1:0]      NEG_LIMIT  = 17'h08000;
  localparam logic [Q_W-1:0]      POS_LIMIT  = 17'h07FFF;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    MODE_FADE_IN  = 2'd0,
    MODE_FADE_OUT = 2'd1,
    MODE_MEASURE  = 2'd2,
    MODE_APPLY    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_CHK,
    BS_DIV,
    BS_DONE
  } back_state_t;

  // one classified sample pair travelling from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [OP_W-1:0]            num;
    logic [OP_W-1:0]            den;
    logic                       scale;
    logic [SAMPLE_W-1:0]        peak;
  } item_t;

  // magnitude of a two's complement sample, 0..32768
  function automatic logic [SAMPLE_W-1:0] abs_sample(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] neg;
    neg = SAMPLE_W'(-s);
    return s[SAMPLE_W-1] ? neg : SAMPLE_W'(s);
  endfunction

endpackage

>>> hdl/afn_queue.sv
// two-entry fifo between the front classifier and the back scaler
// depends on afn_pkg
module afn_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  afn_pkg::item_t push_data,
  output logic          full,
  input  logic          pop,
  output afn_pkg::item_t pop_data,
  output logic          not_empty
);

  afn_pkg::item_t                  mem_r [afn_pkg::QUEUE_DEPTH];
  logic [afn_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [afn_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [afn_pkg::QPTR_W:0]        count_r, count_nxt;

  assign full      = (count_r == (afn_pkg::QPTR_W+1)'(afn_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/afn_front.sv
// front end: config registers, position counter, peak tracking and item classification
// depends on afn_pkg
module afn_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [afn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [afn_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [afn_pkg::SAMPLE_W-1:0] in_left,
  input  logic signed [afn_pkg::SAMPLE_W-1:0] in_right,
  input  logic                                q_full,
  output logic                                push,
  output afn_pkg::item_t                      push_data
);

  afn_pkg::mode_t                     mode_r, mode_nxt;
  logic [afn_pkg::LENGTH_BITS-1:0]    len_r, len_nxt;
  logic [afn_pkg::LENGTH_BITS-1:0]    pos_r, pos_nxt;
  logic [afn_pkg::SAMPLE_W-1:0]       peak_r, peak_nxt;

  logic                               active;
  logic [afn_pkg::SAMPLE_W-1:0]       abs_l, abs_r;
  logic [afn_pkg::SAMPLE_W-1:0]       peak_upd;
  afn_pkg::mode_t                     cfg_mode;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign cfg_mode = afn_pkg::mode_t'(cfg_data[1:0]);

  // an item is worked on only inside a range of two or more pairs
  assign active = (len_r >= afn_pkg::LENGTH_BITS'(2)) && (pos_r < len_r);

  // running peak over both channels
  always_comb begin
    abs_l    = afn_pkg::abs_sample(in_left);
    abs_r    = afn_pkg::abs_sample(in_right);
    peak_upd = peak_r;
    if (abs_l > peak_upd) begin
      peak_upd = abs_l;
    end
    if (abs_r > peak_upd) begin
      peak_upd = abs_r;
    end
  end

  // classify the incoming pair
  always_comb begin
    push_data.left  = in_left;
    push_data.right = in_right;
    push_data.num   = '0;
    push_data.den   = afn_pkg::OP_W'(len_r);
    push_data.scale = 1'b0;
    push_data.peak  = peak_r;
    peak_nxt        = peak_r;
    unique case (mode_r)
      afn_pkg::MODE_FADE_IN: begin
        push_data.scale = active;
        push_data.num   = afn_pkg::OP_W'(pos_r);
      end
      afn_pkg::MODE_FADE_OUT: begin
        push_data.scale = active;
        push_data.num   = afn_pkg::OP_W'(len_r - pos_r);
      end
      afn_pkg::MODE_MEASURE: begin
        if (active) begin
          peak_nxt       = peak_upd;
          push_data.peak = peak_upd;
        end
      end
      afn_pkg::MODE_APPLY: begin
        push_data.scale = active && (peak_r != '0);
        push_data.num   = afn_pkg::OP_W'(afn_pkg::SAMPLE_MAX);
        push_data.den   = afn_pkg::OP_W'(peak_r);
      end
      default: begin
        push_data.scale = 1'b0;
      end
    endcase
  end

  // register writes and per-item state update
  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    if (cfg_we) begin
      case (cfg_index)
        afn_pkg::CFG_MODE: begin
          mode_nxt = cfg_mode;
          pos_nxt  = '0;
        end
        afn_pkg::CFG_LENGTH: begin
          len_nxt = afn_pkg::LENGTH_BITS'(cfg_data);
        end
        default: begin
          len_nxt = len_r;
        end
      endcase
    end else if (push && (pos_r != '1)) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= afn_pkg::MODE_FADE_IN;
      len_r  <= '0;
      pos_r  <= '0;
      peak_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
      if (cfg_we && (cfg_index == afn_pkg::CFG_MODE) && (cfg_mode == afn_pkg::MODE_MEASURE)) begin
        peak_r <= '0;
      end else if (!cfg_we && push) begin
        peak_r <= peak_nxt;
      end
    end
  end

endmodule

>>> hdl/afn_back.sv
// back end: shared multiplier and restoring divider, clamp, output register
// depends on afn_pkg
module afn_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_not_empty,
  input  afn_pkg::item_t                      q_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [afn_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [afn_pkg::SAMPLE_W-1:0] out_right,
  output logic [afn_pkg::SAMPLE_W-1:0]        out_peak
);

  afn_pkg::back_state_t               state_r, state_nxt;
  afn_pkg::item_t                     item_r;
  logic                               chan_r;
  logic [afn_pkg::PROD_W-1:0]         rem_r;
  logic [afn_pkg::PROD_W-1:0]         dsh_r;
  logic [afn_pkg::Q_W-1:0]            quo_r;
  logic [afn_pkg::STEP_W-1:0]         step_r;
  logic                               ovf_r;
  logic signed [afn_pkg::SAMPLE_W-1:0] res_r [2];
  logic                               out_valid_r;

  logic signed [afn_pkg::SAMPLE_W-1:0] sample;
  logic [afn_pkg::Q_W-1:0]            mag;
  logic                               fits;
  logic [afn_pkg::Q_W-1:0]            quo_fin;
  logic [afn_pkg::Q_W-1:0]            mag_res;
  logic signed [afn_pkg::SAMPLE_W-1:0] chan_res;
  logic                               div_last;
  logic                               out_load;

  assign out_valid = out_valid_r;
  assign sample    = chan_r ? item_r.right : item_r.left;
  assign mag       = afn_pkg::Q_W'(afn_pkg::abs_sample(sample));
  assign div_last  = (step_r == afn_pkg::STEP_W'(afn_pkg::Q_W - 1));

  // one quotient bit per cycle
  assign fits    = (rem_r >= dsh_r);
  assign quo_fin = {quo_r[afn_pkg::Q_W-2:0], fits};

  // clamp magnitude and restore sign
  always_comb begin
    mag_res = quo_fin;
    if (ovf_r || (quo_fin > afn_pkg::NEG_LIMIT)) begin
      mag_res = afn_pkg::NEG_LIMIT;
    end
    if (sample[afn_pkg::SAMPLE_W-1]) begin
      chan_res = afn_pkg::SAMPLE_W'(-mag_res);
    end else if (mag_res > afn_pkg::POS_LIMIT) begin
      chan_res = afn_pkg::SAMPLE_MAX;
    end else begin
      chan_res = afn_pkg::SAMPLE_W'(mag_res);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      afn_pkg::BS_IDLE: begin
        if (q_not_empty) begin
          state_nxt = q_data.scale ? afn_pkg::BS_MUL : afn_pkg::BS_DONE;
        end
      end
      afn_pkg::BS_MUL: state_nxt = afn_pkg::BS_CHK;
      afn_pkg::BS_CHK: state_nxt = afn_pkg::BS_DIV;
      afn_pkg::BS_DIV: begin
        if (div_last) begin
          state_nxt = chan_r ? afn_pkg::BS_DONE : afn_pkg::BS_MUL;
        end
      end
      afn_pkg::BS_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = afn_pkg::BS_IDLE;
        end
      end
      default: state_nxt = afn_pkg::BS_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      afn_pkg::BS_IDLE: pop      = q_not_empty;
      afn_pkg::BS_DONE: out_load = !out_valid_r || out_ready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afn_pkg::BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scaler datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r   <= q_data;
      chan_r   <= 1'b0;
      res_r[0] <= q_data.left;
      res_r[1] <= q_data.right;
    end
    if (state_r == afn_pkg::BS_MUL) begin
      rem_r <= afn_pkg::PROD_W'(mag * item_r.num);
    end
    if (state_r == afn_pkg::BS_CHK) begin
      ovf_r  <= (rem_r >= {item_r.den, afn_pkg::Q_W'(0)});
      dsh_r  <= {1'b0, item_r.den, afn_pkg::SAMPLE_W'(0)};
      quo_r  <= '0;
      step_r <= '0;
    end
    if (state_r == afn_pkg::BS_DIV) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r  <= dsh_r >> 1;
      quo_r  <= quo_fin;
      step_r <= step_r + 1'b1;
      if (div_last) begin
        res_r[chan_r] <= chan_res;
        chan_r        <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left  <= res_r[0];
      out_right <= res_r[1];
      out_peak  <= item_r.peak;
    end
  end

endmodule

>>> hdl/audio_fade_normalize.sv
// Linear fade and peak normalize for stereo 16-bit PCM.
// Input channel: in_valid / in_ready with one sample pair per beat.
// Output channel: out_valid / out_ready with one processed pair per input
// beat, plus the running peak level, in input order.
// Config: cfg_we writes cfg_data into register cfg_index (0 mode, 1 length)
// in the same cycle; a mode write restarts the position count, and selecting
// measure mode also clears the peak. Write only while no beat is in flight.
// Scaled pairs use one shared 17x32 multiplier and a 17-step restoring
// divider, once per channel; pass-through pairs skip both. The back-end
// scaler takes one pair at a time and so sets the throughput.
// A two-entry queue sits between the classifier and the scaler, so the input
// keeps accepting while a result waits at the output; when out_ready stays low
// the queue fills and in_ready drops after four pairs are held.
// Reset (rst_n low, synchronous) clears mode, length, position, peak, the queue
// and out_valid.
// depends on afn_pkg, afn_queue, afn_front, afn_back
module audio_fade_normalize (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [afn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [afn_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [afn_pkg::SAMPLE_W-1:0] in_left_in,
  input  logic signed [afn_pkg::SAMPLE_W-1:0] in_right_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [afn_pkg::SAMPLE_W-1:0] out_left_out,
  output logic signed [afn_pkg::SAMPLE_W-1:0] out_right_out,
  output logic [afn_pkg::SAMPLE_W-1:0]        out_peak_level
);

  logic           push;
  logic           q_full;
  logic           q_not_empty;
  logic           pop;
  afn_pkg::item_t push_data;
  afn_pkg::item_t pop_data;

  // classifier
  afn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_left   (in_left_in),
    .in_right  (in_right_in),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  afn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty)
  );

  // scaler and output stage
  afn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_left    (out_left_out),
    .out_right   (out_right_out),
    .out_peak    (out_peak_level)
  );

endmodule

>>> hdl/afn_checker.sv
// port-level checker for audio_fade_normalize, attached by bind
// depends on afn_pkg and assert_macros.svh
`include "assert_macros.svh"

module afn_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [afn_pkg::SAMPLE_W-1:0] out_left_out,
  input logic signed [afn_pkg::SAMPLE_W-1:0] out_right_out,
  input logic [afn_pkg::SAMPLE_W-1:0]        out_peak_level
);

  logic [2:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // beats accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `AFN_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_valid)
  `AFN_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_left_out) && $stable(out_right_out) && $stable(out_peak_level))
  `AFN_ASSERT(a_peak_range, out_valid |-> out_peak_level <= 16'h8000)
  `AFN_ASSERT(a_no_extra_out, out_valid |-> pend_r != 3'd0)
  `AFN_ASSERT(a_capacity, pend_r <= 3'd4)

endmodule

bind audio_fade_normalize afn_checker u_afn_checker (.*);
